[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the dispatcher checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MQJD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MQJD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/mqjd_pkg.sv]
// ----------------------------------------------------------------------------
// mqjd_pkg
// Types, codes and helpers shared by the multi-queue job dispatcher.
// ----------------------------------------------------------------------------
package mqjd_pkg;

  localparam int NUM_QUEUES_DEF  = 64;
  localparam int QUEUE_DEPTH_DEF = 128;

  localparam int JOB_ID_W   = 16;
  localparam int BURST_W    = 16;
  localparam int PROC_W     = 6;
  localparam int QIDX_W     = 6;
  localparam int MODE_W     = 2;
  localparam int PCOUNT_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int JOB_W      = JOB_ID_W + BURST_W;
  localparam int STEP_W     = $clog2(JOB_ID_W);

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } mqjd_kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SINGLE = 2'd0,
    MODE_MODULO = 2'd1,
    MODE_LEAST  = 2'd2
  } mqjd_mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } mqjd_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISPATCH_MODE = 1'b0,
    CFG_PROC_COUNT    = 1'b1
  } mqjd_cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_LOOKUP,
    S_EXEC,
    S_JREAD,
    S_FIN
  } mqjd_state_t;

  typedef struct packed {
    mqjd_kind_t          kind;
    logic [JOB_ID_W-1:0] job_id;
    logic [BURST_W-1:0]  job_len;
    logic [PROC_W-1:0]   processor;
  } mqjd_in_item_t;

  typedef struct packed {
    mqjd_status_t        status;
    logic [QIDX_W-1:0]   queue_index;
    logic [JOB_ID_W-1:0] out_job_id;
    logic [BURST_W-1:0]  out_job_len;
  } mqjd_out_item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mqjd_mem_ctl_t;

  // Width of a queue index for a given queue count.
  function automatic int qidx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Width of the shared subtractor: fits a queue count and a shifted remainder.
  function automatic int sub_w(input int depth);
    return ($clog2(depth + 1) > PCOUNT_W + 1) ? $clog2(depth + 1) : PCOUNT_W + 1;
  endfunction

endpackage

[sv/mqjd_sub.sv]
// ----------------------------------------------------------------------------
// mqjd_sub
// Shared subtract/compare unit: difference and borrow of two unsigned words.
// ----------------------------------------------------------------------------
module mqjd_sub #(
  parameter int AW = 13
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  output logic [AW-1:0] diff,
  output logic          borrow
);

  // borrow set means a < b
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

[sv/mqjd_qtab.sv]
// ----------------------------------------------------------------------------
// mqjd_qtab
// Per-queue head, tail and count table with one read and one write port.
// ----------------------------------------------------------------------------
module mqjd_qtab #(
  parameter  int NUM_QUEUES  = 64,
  parameter  int QUEUE_DEPTH = 128,
  localparam int QW          = mqjd_pkg::qidx_w(NUM_QUEUES),
  localparam int PW          = $clog2(QUEUE_DEPTH),
  localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mqjd_pkg::mqjd_mem_ctl_t ctl,
  input  logic [QW-1:0]           rd_addr,
  input  logic [QW-1:0]           wr_addr,
  input  logic [PW-1:0]           wr_head,
  input  logic [PW-1:0]           wr_tail,
  input  logic [CW-1:0]           wr_cnt,
  output logic [PW-1:0]           rd_head,
  output logic [PW-1:0]           rd_tail,
  output logic [CW-1:0]           rd_cnt
);

  import mqjd_pkg::*;

  localparam int EW = PW + PW + CW;

  logic [EW-1:0]         mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] vld_r;
  logic [EW-1:0]         rd_word_r;
  logic                  rd_vld_r;
  logic [EW-1:0]         rd_word;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_head, wr_tail, wr_cnt};
    end
  end

  // Entries never written read as empty queues.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_word_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign rd_word = rd_vld_r ? rd_word_r : '0;
  assign {rd_head, rd_tail, rd_cnt} = rd_word;

endmodule

[sv/mqjd_jobmem.sv]
// ----------------------------------------------------------------------------
// mqjd_jobmem
// Job store: one slot per queue entry, single port, registered read.
// ----------------------------------------------------------------------------
module mqjd_jobmem #(
  parameter int AMW = 13,
  parameter int DW  = 32
) (
  input  logic                    clk,
  input  mqjd_pkg::mqjd_mem_ctl_t ctl,
  input  logic [AMW-1:0]          addr,
  input  logic [DW-1:0]           wr_data,
  output logic [DW-1:0]           rd_data
);

  import mqjd_pkg::*;

  logic [DW-1:0] mem [2**AMW];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/mqjd_ctrl.sv]
// ----------------------------------------------------------------------------
// mqjd_ctrl
// Sequencer: queue selection (fixed, by modulo or by scan), then enqueue or dequeue.
// ----------------------------------------------------------------------------
module mqjd_ctrl #(
  parameter  int NUM_QUEUES  = 64,
  parameter  int QUEUE_DEPTH = 128,
  localparam int QW          = mqjd_pkg::qidx_w(NUM_QUEUES),
  localparam int PW          = $clog2(QUEUE_DEPTH),
  localparam int CW          = $clog2(QUEUE_DEPTH + 1),
  localparam int AW          = mqjd_pkg::sub_w(QUEUE_DEPTH),
  localparam int NW          = mqjd_pkg::PCOUNT_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_accept,
  input  mqjd_pkg::mqjd_in_item_t  in_item,
  input  logic [mqjd_pkg::MODE_W-1:0] mode,
  input  logic [NW-1:0]            n_eff,
  input  logic                     out_free,
  output logic                     busy,
  output logic                     res_load,
  output mqjd_pkg::mqjd_out_item_t res,
  output mqjd_pkg::mqjd_mem_ctl_t  qt_ctl,
  output logic [QW-1:0]            qt_rd_addr,
  output logic [QW-1:0]            qt_wr_addr,
  output logic [PW-1:0]            qt_wr_head,
  output logic [PW-1:0]            qt_wr_tail,
  output logic [CW-1:0]            qt_wr_cnt,
  input  logic [PW-1:0]            qt_rd_head,
  input  logic [PW-1:0]            qt_rd_tail,
  input  logic [CW-1:0]            qt_rd_cnt,
  output mqjd_pkg::mqjd_mem_ctl_t  jm_ctl,
  output logic [QW+PW-1:0]         jm_addr,
  output logic [mqjd_pkg::JOB_W-1:0] jm_wr_data,
  input  logic [mqjd_pkg::JOB_W-1:0] jm_rd_data,
  output logic [AW-1:0]            sub_a,
  output logic [AW-1:0]            sub_b,
  input  logic [AW-1:0]            sub_diff,
  input  logic                     sub_borrow
);

  import mqjd_pkg::*;

  mqjd_state_t         state_r, state_nxt;
  mqjd_in_item_t       item_r, item_nxt;
  logic [JOB_ID_W-1:0] k_r, k_nxt;
  logic [NW-1:0]       rem_r, rem_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [NW-1:0]       scan_idx_r, scan_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [NW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [NW-1:0]       best_idx_r, best_idx_nxt;
  logic [CW-1:0]       best_cnt_r, best_cnt_nxt;
  logic [QW-1:0]       q_r, q_nxt;
  mqjd_out_item_t      res_r, res_nxt;
  logic [NW:0]         div_acc;
  logic                take;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    k_r        <= k_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_cnt_r <= best_cnt_nxt;
    q_r        <= q_nxt;
    res_r      <= res_nxt;
  end

  assign div_acc = {rem_r, k_r[JOB_ID_W-1]};

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    k_nxt        = k_r;
    rem_nxt      = rem_r;
    step_nxt     = step_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    best_idx_nxt = best_idx_r;
    best_cnt_nxt = best_cnt_r;
    q_nxt        = q_r;
    res_nxt      = res_r;
    busy         = 1'b1;
    res_load     = 1'b0;
    qt_ctl       = '0;
    qt_rd_addr   = q_r;
    qt_wr_addr   = q_r;
    qt_wr_head   = qt_rd_head;
    qt_wr_tail   = qt_rd_tail;
    qt_wr_cnt    = qt_rd_cnt;
    jm_ctl       = '0;
    jm_addr      = {q_r, qt_rd_tail};
    jm_wr_data   = {item_r.job_id, item_r.job_len};
    sub_a        = AW'(div_acc);
    sub_b        = AW'(n_eff);
    take         = 1'b0;

    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (in_accept) begin
          item_nxt     = in_item;
          k_nxt        = in_item.job_id - JOB_ID_W'(1);
          rem_nxt      = '0;
          step_nxt     = STEP_W'(JOB_ID_W - 1);
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          q_nxt        = '0;
          state_nxt    = S_LOOKUP;
          if (in_item.kind == KIND_ENQ) begin
            if (mode == MODE_MODULO) begin
              state_nxt = S_DIV;
            end else if (mode == MODE_LEAST) begin
              state_nxt = S_SCAN;
            end
          end else if (mode == MODE_MODULO || mode == MODE_LEAST) begin
            if (32'(in_item.processor) >= NUM_QUEUES) begin
              // no such queue: report empty against the named processor
              res_nxt.status      = ST_EMPTY;
              res_nxt.queue_index = QIDX_W'(in_item.processor);
              res_nxt.out_job_id  = '0;
              res_nxt.out_job_len = '0;
              state_nxt           = S_FIN;
            end else begin
              q_nxt = QW'(in_item.processor);
            end
          end
        end
      end

      S_DIV: begin
        // one restoring step of (job_id - 1) mod n per cycle
        sub_a    = AW'(div_acc);
        sub_b    = AW'(n_eff);
        rem_nxt  = sub_borrow ? NW'(div_acc) : NW'(sub_diff);
        k_nxt    = k_r << 1;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          q_nxt     = QW'(rem_nxt);
          state_nxt = S_LOOKUP;
        end
      end

      S_SCAN: begin
        // issue count reads one queue ahead of the compare
        qt_rd_addr = QW'(scan_idx_r);
        if (scan_idx_r < n_eff) begin
          qt_ctl.rd_en = 1'b1;
          scan_idx_nxt = scan_idx_r + NW'(1);
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r;
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        sub_a = AW'(qt_rd_cnt);
        sub_b = AW'(best_cnt_r);
        if (cmp_vld_r) begin
          take = (cmp_idx_r == '0) || sub_borrow;
          if (take) begin
            best_cnt_nxt = qt_rd_cnt;
            best_idx_nxt = cmp_idx_r;
          end
          if (cmp_idx_r == n_eff - NW'(1)) begin
            q_nxt       = take ? QW'(cmp_idx_r) : QW'(best_idx_r);
            cmp_vld_nxt = 1'b0;
            state_nxt   = S_LOOKUP;
          end
        end
      end

      S_LOOKUP: begin
        qt_ctl.rd_en = 1'b1;
        qt_rd_addr   = q_r;
        state_nxt    = S_EXEC;
      end

      S_EXEC: begin
        res_nxt.queue_index = QIDX_W'(q_r);
        state_nxt           = S_FIN;
        if (item_r.kind == KIND_ENQ) begin
          res_nxt.out_job_id  = item_r.job_id;
          res_nxt.out_job_len = item_r.job_len;
          if (qt_rd_cnt == CW'(QUEUE_DEPTH)) begin
            res_nxt.status = ST_FULL;
          end else begin
            res_nxt.status = ST_DONE;
            qt_ctl.wr_en   = 1'b1;
            qt_wr_tail     = adv(qt_rd_tail);
            qt_wr_cnt      = qt_rd_cnt + CW'(1);
            jm_ctl.wr_en   = 1'b1;
            jm_addr        = {q_r, qt_rd_tail};
          end
        end else begin
          if (qt_rd_cnt == '0) begin
            res_nxt.status      = ST_EMPTY;
            res_nxt.out_job_id  = '0;
            res_nxt.out_job_len = '0;
          end else begin
            res_nxt.status = ST_DONE;
            qt_ctl.wr_en   = 1'b1;
            qt_wr_head     = adv(qt_rd_head);
            qt_wr_cnt      = qt_rd_cnt - CW'(1);
            jm_ctl.rd_en   = 1'b1;
            jm_addr        = {q_r, qt_rd_head};
            state_nxt      = S_JREAD;
          end
        end
      end

      S_JREAD: begin
        res_nxt.out_job_id  = jm_rd_data[JOB_W-1:BURST_W];
        res_nxt.out_job_len = jm_rd_data[BURST_W-1:0];
        state_nxt           = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

[sv/multi_queue_job_dispatcher.sv]
// ----------------------------------------------------------------------------
// multi_queue_job_dispatcher
// Places jobs into per-processor FIFO queues and hands them out on request.
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds in_stall high until that
// item's result is loaded into the output register. An enqueue item picks a
// queue by the dispatch mode: queue 0 (single mode, also for the undefined
// mode code), (job_id-1) mod the processor count (modulo mode), or the
// lowest-index queue with the fewest entries (least-loaded mode). A full
// target rejects the job with status full and leaves every queue as it
// was. A dequeue item pops the head of the named processor's queue (queue 0
// in single mode) or reports empty. An enqueue in single mode goes straight
// to the queue-table read; modulo mode first runs 16 restoring steps in
// the shared subtractor; least-loaded mode first reads the queue table once
// per queue of the clamped processor count, compared in the same subtractor;
// a dequeue does the queue-table read, then the job-store read. A processor
// count of 0 acts as 1 and a count above NUM_QUEUES is clamped.
// The queue table is ready right after reset; there is no clearing pass.
// Results sit in an output register, so a new item is taken while the last
// result still waits on out_stall.
// ----------------------------------------------------------------------------
module multi_queue_job_dispatcher #(
  parameter int NUM_QUEUES  = mqjd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqjd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mqjd_pkg::mqjd_in_item_t           in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mqjd_pkg::mqjd_out_item_t          out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mqjd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mqjd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import mqjd_pkg::*;

  localparam int QW  = qidx_w(NUM_QUEUES);
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int AW  = sub_w(QUEUE_DEPTH);
  localparam int AMW = QW + PW;

  logic [MODE_W-1:0]   mode_r;
  logic [PCOUNT_W-1:0] pcount_r;
  logic [PCOUNT_W-1:0] n_eff;

  logic                out_valid_r;
  mqjd_out_item_t      out_item_r;
  logic                out_free;

  logic                busy;
  logic                res_load;
  mqjd_out_item_t      res;

  mqjd_mem_ctl_t       qt_ctl;
  logic [QW-1:0]       qt_rd_addr;
  logic [QW-1:0]       qt_wr_addr;
  logic [PW-1:0]       qt_wr_head;
  logic [PW-1:0]       qt_wr_tail;
  logic [CW-1:0]       qt_wr_cnt;
  logic [PW-1:0]       qt_rd_head;
  logic [PW-1:0]       qt_rd_tail;
  logic [CW-1:0]       qt_rd_cnt;

  mqjd_mem_ctl_t       jm_ctl;
  logic [AMW-1:0]      jm_addr;
  logic [JOB_W-1:0]    jm_wr_data;
  logic [JOB_W-1:0]    jm_rd_data;

  logic [AW-1:0]       sub_a;
  logic [AW-1:0]       sub_b;
  logic [AW-1:0]       sub_diff;
  logic                sub_borrow;

  // Config writes are to be made while the block is idle; the block itself does not enforce it and always takes them.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SINGLE;
      pcount_r <= PCOUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DISPATCH_MODE: mode_r   <= cfg_data[MODE_W-1:0];
        CFG_PROC_COUNT:    pcount_r <= cfg_data[PCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the processor count into 1..NUM_QUEUES.
  always_comb begin
    if (pcount_r == '0) begin
      n_eff = PCOUNT_W'(1);
    end else if (32'(pcount_r) > NUM_QUEUES) begin
      n_eff = PCOUNT_W'(NUM_QUEUES);
    end else begin
      n_eff = pcount_r;
    end
  end

  // Output register: load a finished result, drop it once taken.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign in_stall  = busy;

  mqjd_ctrl #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_valid && !in_stall),
    .in_item    (in_item),
    .mode       (mode_r),
    .n_eff      (n_eff),
    .out_free   (out_free),
    .busy       (busy),
    .res_load   (res_load),
    .res        (res),
    .qt_ctl     (qt_ctl),
    .qt_rd_addr (qt_rd_addr),
    .qt_wr_addr (qt_wr_addr),
    .qt_wr_head (qt_wr_head),
    .qt_wr_tail (qt_wr_tail),
    .qt_wr_cnt  (qt_wr_cnt),
    .qt_rd_head (qt_rd_head),
    .qt_rd_tail (qt_rd_tail),
    .qt_rd_cnt  (qt_rd_cnt),
    .jm_ctl     (jm_ctl),
    .jm_addr    (jm_addr),
    .jm_wr_data (jm_wr_data),
    .jm_rd_data (jm_rd_data),
    .sub_a      (sub_a),
    .sub_b      (sub_b),
    .sub_diff   (sub_diff),
    .sub_borrow (sub_borrow)
  );

  mqjd_sub #(
    .AW (AW)
  ) u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  mqjd_qtab #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_qtab (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (qt_ctl),
    .rd_addr (qt_rd_addr),
    .wr_addr (qt_wr_addr),
    .wr_head (qt_wr_head),
    .wr_tail (qt_wr_tail),
    .wr_cnt  (qt_wr_cnt),
    .rd_head (qt_rd_head),
    .rd_tail (qt_rd_tail),
    .rd_cnt  (qt_rd_cnt)
  );

  mqjd_jobmem #(
    .AMW (AMW),
    .DW  (JOB_W)
  ) u_jobmem (
    .clk     (clk),
    .ctl     (jm_ctl),
    .addr    (jm_addr),
    .wr_data (jm_wr_data),
    .rd_data (jm_rd_data)
  );

endmodule

[sv/mqjd_checker.sv]
// ----------------------------------------------------------------------------
// mqjd_checker
// Port-level checks of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mqjd_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input mqjd_pkg::mqjd_out_item_t out_item
);

  import mqjd_pkg::*;

  logic in_take;
  logic empty_has_job;

  assign in_take       = in_valid && !in_stall;
  assign empty_has_job = (out_item.status == ST_EMPTY) &&
                         (out_item.out_job_id != '0 || out_item.out_job_len != '0);

  // One item at a time: the block goes busy right after an accept.
  `MQJD_ASSERT(a_busy_after_accept, clk, rst_n, in_take |=> in_stall, "not busy after accept")

  // A new result only appears after the block was working on an item.
  `MQJD_ASSERT(a_res_from_work, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "no work")

  // An empty report carries no job.
  `MQJD_ASSERT(a_empty_zero, clk, rst_n, out_valid |-> !empty_has_job, "empty with job")

  // A stalled result stays offered.
  `MQJD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped")

endmodule

bind multi_queue_job_dispatcher mqjd_checker u_mqjd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
